>>> sv/qmm_pkg.sv
// shared types and constants for the quad motor mixer
package qmm_pkg;

	localparam int unsigned STICK_FULL = 32767;
	localparam int unsigned THRUST_MAX = 65535;

	localparam logic [1:0] CFG_MIX_SIGNS = 2'd0;
	localparam logic [1:0] CFG_ESC_MIN   = 2'd1;
	localparam logic [1:0] CFG_ESC_MAX   = 2'd2;

	localparam logic [11:0] MIX_SIGNS_RST = 12'hEA1;
	localparam logic [15:0] ESC_MIN_RST   = 16'd1000;
	localparam logic [15:0] ESC_MAX_RST   = 16'd2000;

	// load strobes for the two register stages inside a sub-unit
	typedef struct packed {
		logic first;
		logic second;
	} qmm_ld_t;

endpackage

>>> sv/quad_motor_mixer_raw_top.sv
// quad x-frame motor mixer top level: config registers, mix pipeline, esc map
// throughput: one item per cycle through a five-stage pipeline while the output is not stalled
// stages: multiply, divide by 32767, mix and clamp, span multiply, divide and offset
// a stalled output holds its stage; empty stages ahead still fill
// reset clears all stage valid bits and loads the register defaults
module quad_motor_mixer_raw_top import qmm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] throttle,
	input  logic signed [15:0] aileron,
	input  logic signed [15:0] elevator,
	input  logic signed [15:0] rudder,
	input  logic               link_active,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        thrust_one,
	output logic [15:0]        thrust_two,
	output logic [15:0]        thrust_three,
	output logic [15:0]        thrust_four,
	output logic [15:0]        pulse_one,
	output logic [15:0]        pulse_two,
	output logic [15:0]        pulse_three,
	output logic [15:0]        pulse_four,
	output logic               motors_enabled
);

	logic [11:0] mix_signs_q;
	logic [15:0] esc_min_q;
	logic [15:0] esc_max_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic ld1, ld2, ld3, ld4, ld5;

	logic [15:0] level;
	logic [15:0] level_s1, level_s2;
	logic        active_s1, active_s2, active_s3, active_s4, active_s5;
	logic signed [17:0] term_s2 [3];
	logic [15:0] thrust_s3 [4];
	logic [15:0] thrust_s4 [4];
	logic [15:0] thrust_s5 [4];
	logic [15:0] pulse_s5 [4];
	logic [15:0] mix_thrust [4];
	qmm_ld_t     term_ld;
	qmm_ld_t     pulse_ld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_signs_q <= MIX_SIGNS_RST;
			esc_min_q   <= ESC_MIN_RST;
			esc_max_q   <= ESC_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIX_SIGNS: mix_signs_q <= cfg_data[11:0];
				CFG_ESC_MIN:   esc_min_q   <= cfg_data;
				CFG_ESC_MAX:   esc_max_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage takes new data when it is empty or its successor moves
	assign rdy5 = !valid_s5 || !out_stall;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign ld1 = rdy1 && in_valid;
	assign ld2 = rdy2 && valid_s1;
	assign ld3 = rdy3 && valid_s2;
	assign ld4 = rdy4 && valid_s3;
	assign ld5 = rdy5 && valid_s4;

	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	// offset throttle to 0..65535
	assign level = {~throttle[15], throttle[14:0]};

	assign term_ld  = '{first: ld1, second: ld2};
	assign pulse_ld = '{first: ld4, second: ld5};

	qmm_term u_term_roll (
		.clk(clk), .ld(term_ld), .level(level), .stick(aileron), .term_s2(term_s2[0])
	);
	qmm_term u_term_pitch (
		.clk(clk), .ld(term_ld), .level(level), .stick(elevator), .term_s2(term_s2[1])
	);
	qmm_term u_term_yaw (
		.clk(clk), .ld(term_ld), .level(level), .stick(rudder), .term_s2(term_s2[2])
	);

	always_ff @(posedge clk) begin
		if (ld1) begin
			level_s1  <= level;
			active_s1 <= link_active;
		end
		if (ld2) begin
			level_s2  <= level_s1;
			active_s2 <= active_s1;
		end
	end

	// mix and clamp per motor
	always_comb begin
		logic signed [19:0] acc;
		for (int k = 0; k < 4; k++) begin
			acc = $signed({4'b0, level_s2});
			for (int j = 0; j < 3; j++) begin
				if (mix_signs_q[3 * k + j])
					acc = acc - 20'(term_s2[j]);
				else
					acc = acc + 20'(term_s2[j]);
			end
			if (acc < 20'sd0)
				mix_thrust[k] = 16'd0;
			else if (acc > 20'(THRUST_MAX))
				mix_thrust[k] = 16'(THRUST_MAX);
			else
				mix_thrust[k] = acc[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			thrust_s3 <= mix_thrust;
			active_s3 <= active_s2;
		end
		if (ld4) begin
			thrust_s4 <= thrust_s3;
			active_s4 <= active_s3;
		end
		if (ld5) begin
			thrust_s5 <= thrust_s4;
			active_s5 <= active_s4;
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_pulse
		qmm_pulse u_pulse (
			.clk(clk),
			.ld(pulse_ld),
			.thrust(thrust_s3[k]),
			.esc_min(esc_min_q),
			.esc_max(esc_max_q),
			.pulse_s5(pulse_s5[k])
		);
	end

	// shutdown forces every field to zero
	assign out_valid      = valid_s5;
	assign motors_enabled = valid_s5 && active_s5;
	assign thrust_one     = active_s5 ? thrust_s5[0] : 16'd0;
	assign thrust_two     = active_s5 ? thrust_s5[1] : 16'd0;
	assign thrust_three   = active_s5 ? thrust_s5[2] : 16'd0;
	assign thrust_four    = active_s5 ? thrust_s5[3] : 16'd0;
	assign pulse_one      = active_s5 ? pulse_s5[0] : 16'd0;
	assign pulse_two      = active_s5 ? pulse_s5[1] : 16'd0;
	assign pulse_three    = active_s5 ? pulse_s5[2] : 16'd0;
	assign pulse_four     = active_s5 ? pulse_s5[3] : 16'd0;

	a_shutdown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !motors_enabled |->
			thrust_one == 16'd0 && thrust_four == 16'd0 &&
			pulse_one == 16'd0 && pulse_four == 16'd0)
		else $error("shutdown item carries nonzero motor outputs");

	a_enabled_valid: assert property (@(posedge clk) disable iff (!arst_n)
		motors_enabled |-> out_valid)
		else $error("motors enabled without a result item");

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |-> !in_stall)
		else $error("input stalled while the pipeline advances");

	a_fill_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !valid_s5 |=> valid_s5)
		else $error("item lost between the last two stages");

endmodule

>>> sv/qmm_term.sv
// stick term unit: -(level * stick) / 32767 truncated, two register stages
module qmm_term import qmm_pkg::*; (
	input  logic               clk,
	input  qmm_ld_t            ld,
	input  logic [15:0]        level,
	input  logic signed [15:0] stick,
	output logic signed [17:0] term_s2
);

	logic [15:0] mag;
	logic        neg;
	logic [31:0] prod_s1;
	logic        neg_s1;
	logic [16:0] hi;
	logic [14:0] lo;
	logic [17:0] rem;
	logic [1:0]  corr;
	logic [16:0] quo;

	assign mag = stick[15] ? 16'(-stick) : 16'(stick);
	assign neg = !stick[15] && (stick != 16'sd0);

	always_ff @(posedge clk) begin
		if (ld.first) begin
			prod_s1 <= {16'b0, level} * {16'b0, mag};
			neg_s1  <= neg;
		end
	end

	// a = hi * 32767 + (hi + lo)
	assign hi  = prod_s1[31:15];
	assign lo  = prod_s1[14:0];
	assign rem = {1'b0, hi} + {3'b0, lo};

	always_comb begin
		if (rem >= 18'(3 * STICK_FULL))
			corr = 2'd3;
		else if (rem >= 18'(2 * STICK_FULL))
			corr = 2'd2;
		else if (rem >= 18'(STICK_FULL))
			corr = 2'd1;
		else
			corr = 2'd0;
	end

	assign quo = hi + {15'b0, corr};

	always_ff @(posedge clk) begin
		if (ld.second) begin
			term_s2 <= neg_s1 ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		end
	end

endmodule

>>> sv/qmm_pulse.sv
// esc map unit: min + thrust * (max - min) / 65535 truncated, two register stages
module qmm_pulse import qmm_pkg::*; (
	input  logic        clk,
	input  qmm_ld_t     ld,
	input  logic [15:0] thrust,
	input  logic [15:0] esc_min,
	input  logic [15:0] esc_max,
	output logic [15:0] pulse_s5
);

	logic        down;
	logic [15:0] span;
	logic [31:0] prod_s4;
	logic [15:0] hi;
	logic [15:0] lo;
	logic [16:0] rem;
	logic [15:0] quo;

	assign down = esc_max < esc_min;
	assign span = down ? (esc_min - esc_max) : (esc_max - esc_min);

	always_ff @(posedge clk) begin
		if (ld.first) begin
			prod_s4 <= {16'b0, thrust} * {16'b0, span};
		end
	end

	// p = hi * 65535 + (hi + lo), and hi + lo stays below 2 * 65535
	assign hi  = prod_s4[31:16];
	assign lo  = prod_s4[15:0];
	assign rem = {1'b0, hi} + {1'b0, lo};
	assign quo = hi + {15'b0, (rem >= 17'(THRUST_MAX))};

	always_ff @(posedge clk) begin
		if (ld.second) begin
			pulse_s5 <= down ? (esc_min - quo) : (esc_min + quo);
		end
	end

endmodule

>>> verif/testbench.sv
// self-checking testbench for the quad motor mixer top level
`timescale 1ns / 1ps

module testbench;
	import qmm_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [15:0] throttle;
		logic [15:0] aileron;
		logic [15:0] elevator;
		logic [15:0] rudder;
		logic        link;
	} stick_frame_t;

	typedef struct packed {
		logic [3:0][15:0] thrust;
		logic [3:0][15:0] pulse;
		logic             enabled;
	} motor_cmd_t;

	class motor_mix_tracker;
		logic [11:0] signs;
		logic [15:0] esc_lo;
		logic [15:0] esc_hi;
		motor_cmd_t  expected_cmds[$];
		int          mismatches;
		int          frames_taken;
		int          cmds_checked;

		function new();
			signs = MIX_SIGNS_RST;
			esc_lo = ESC_MIN_RST;
			esc_hi = ESC_MAX_RST;
			mismatches = 0;
			frames_taken = 0;
			cmds_checked = 0;
		endfunction

		function void write_register(logic [1:0] idx, logic [15:0] data);
			case (idx)
				CFG_MIX_SIGNS: signs = data[11:0];
				CFG_ESC_MIN: esc_lo = data;
				CFG_ESC_MAX: esc_hi = data;
				default: ;
			endcase
		endfunction

		function motor_cmd_t predict_cmd(stick_frame_t f);
			motor_cmd_t c;
			longint level;
			longint terms[3];
			longint m;
			longint lo;
			longint hi;
			longint pulse;
			c = '0;
			level = longint'($signed(f.throttle)) + 32768;
			terms[0] = -(level * longint'($signed(f.aileron))) / longint'(STICK_FULL);
			terms[1] = -(level * longint'($signed(f.elevator))) / longint'(STICK_FULL);
			terms[2] = -(level * longint'($signed(f.rudder))) / longint'(STICK_FULL);
			if (!f.link)
				return c;
			lo = longint'(esc_lo);
			hi = longint'(esc_hi);
			for (int k = 0; k < 4; k++) begin
				m = level;
				for (int j = 0; j < 3; j++) begin
					if (signs[3 * k + j])
						m -= terms[j];
					else
						m += terms[j];
				end
				if (m < 0)
					m = 0;
				if (m > longint'(THRUST_MAX))
					m = longint'(THRUST_MAX);
				pulse = lo + (m * (hi - lo)) / longint'(THRUST_MAX);
				c.thrust[k] = m[15:0];
				c.pulse[k] = pulse[15:0];
			end
			c.enabled = 1'b1;
			return c;
		endfunction

		function void note_frame(stick_frame_t f);
			expected_cmds.push_back(predict_cmd(f));
			frames_taken++;
		endfunction

		task report_mismatch(string what, longint got, longint want);
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
			mismatches++;
		endtask

		task check_cmd(motor_cmd_t got);
			motor_cmd_t want;
			if (expected_cmds.size() == 0) begin
				report_mismatch("result with nothing pending, thrust motor 1",
					got.thrust[0], 0);
				return;
			end
			want = expected_cmds.pop_front();
			cmds_checked++;
			for (int k = 0; k < 4; k++) begin
				if (got.thrust[k] !== want.thrust[k])
					report_mismatch($sformatf("thrust motor %0d", k + 1),
						got.thrust[k], want.thrust[k]);
				if (got.pulse[k] !== want.pulse[k])
					report_mismatch($sformatf("pulse motor %0d", k + 1),
						got.pulse[k], want.pulse[k]);
			end
			if (got.enabled !== want.enabled)
				report_mismatch("motors_enabled", got.enabled, want.enabled);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] throttle;
	logic signed [15:0] aileron;
	logic signed [15:0] elevator;
	logic signed [15:0] rudder;
	logic link_active;
	logic out_valid;
	logic out_stall;
	logic [15:0] thrust_one;
	logic [15:0] thrust_two;
	logic [15:0] thrust_three;
	logic [15:0] thrust_four;
	logic [15:0] pulse_one;
	logic [15:0] pulse_two;
	logic [15:0] pulse_three;
	logic [15:0] pulse_four;
	logic motors_enabled;

	motor_mix_tracker tracker = new();
	int cycle_count = 0;
	int hold_request = 0;
	bit steady = 1'b0;
	int settings_used = 1;

	quad_motor_mixer_raw_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.throttle(throttle),
		.aileron(aileron),
		.elevator(elevator),
		.rudder(rudder),
		.link_active(link_active),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.thrust_one(thrust_one),
		.thrust_two(thrust_two),
		.thrust_three(thrust_three),
		.thrust_four(thrust_four),
		.pulse_one(pulse_one),
		.pulse_two(pulse_two),
		.pulse_three(pulse_three),
		.pulse_four(pulse_four),
		.motors_enabled(motors_enabled)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles", cycle_count);
		$display("TEST FAILED");
		$finish;
	end

	// accepted items and results
	always @(posedge clk) begin
		motor_cmd_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.note_frame({throttle, aileron, elevator, rudder, link_active});
			if (out_valid && !out_stall) begin
				got.thrust = {thrust_four, thrust_three, thrust_two, thrust_one};
				got.pulse = {pulse_four, pulse_three, pulse_two, pulse_one};
				got.enabled = motors_enabled;
				tracker.check_cmd(got);
			end
		end
	end

	// receiver side: random stalls, or a long hold-off on request
	always begin
		@(posedge clk);
		if (hold_request != 0) begin
			out_stall <= 1'b1;
			repeat (hold_request) @(posedge clk);
			hold_request = 0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= !steady && ($urandom_range(99) < 11);
		end
	end

	task automatic send_frame(stick_frame_t f);
		in_valid <= 1'b1;
		throttle <= f.throttle;
		aileron <= f.aileron;
		elevator <= f.elevator;
		rudder <= f.rudder;
		link_active <= f.link;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (!steady && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_sticks(logic [15:0] t, logic [15:0] a, logic [15:0] e,
		logic [15:0] r, logic l);
		send_frame({t, a, e, r, l});
	endtask

	function automatic logic [15:0] pick_channel();
		logic [15:0] v;
		case ($urandom_range(9))
			0: v = 16'h8000;
			1: v = 16'h7fff;
			2: v = 16'h0000;
			3: v = 16'($urandom_range(255)) - 16'd128;
			default: v = 16'($urandom());
		endcase
		return v;
	endfunction

	task automatic send_random(int count);
		stick_frame_t f;
		for (int i = 0; i < count; i++) begin
			f.throttle = pick_channel();
			f.aileron = pick_channel();
			f.elevator = pick_channel();
			f.rudder = pick_channel();
			f.link = ($urandom_range(9) != 0);
			send_frame(f);
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (tracker.expected_cmds.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		tracker.write_register(idx, data);
		@(posedge clk);
	endtask

	task automatic write_settings(logic [15:0] signs, logic [15:0] lo, logic [15:0] hi);
		write_reg(CFG_MIX_SIGNS, signs);
		write_reg(CFG_ESC_MIN, lo);
		write_reg(CFG_ESC_MAX, hi);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic [15:0] span_a;
		logic [15:0] span_b;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MIX_SIGNS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		throttle <= '0;
		aileron <= '0;
		elevator <= '0;
		rudder <= '0;
		link_active <= 1'b0;
		out_stall <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at the reset register values
		send_sticks(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		send_sticks(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		send_sticks(16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 1'b1);
		send_sticks(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 1'b1);
		send_sticks(16'h7fff, 16'h0000, 16'h7fff, 16'h0000, 1'b1);
		send_sticks(16'h7fff, 16'h0000, 16'h8000, 16'h0000, 1'b1);
		send_sticks(16'h7fff, 16'h0000, 16'h0000, 16'h7fff, 1'b1);
		send_sticks(16'h7fff, 16'h0000, 16'h0000, 16'h8000, 1'b1);
		send_sticks(16'h0000, 16'h4000, 16'hc000, 16'h2000, 1'b1);
		send_sticks(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 1'b1);
		send_sticks(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
		send_sticks(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 1'b1);
		send_sticks(16'hffff, 16'h0001, 16'hffff, 16'h0001, 1'b1);
		send_sticks(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 1'b0);
		send_sticks(16'h1234, 16'hedcb, 16'h5555, 16'haaaa, 1'b0);
		send_sticks(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		send_random(170);
		wait_for_results();

		// all terms added, full count range, no idling on either side
		write_reg(CFG_UNUSED, 16'h1234);
		write_settings(16'hf000, 16'h0000, 16'hffff);
		steady = 1'b1;
		send_random(200);
		wait_for_results();
		steady = 1'b0;

		// all terms subtracted, map running downward
		write_settings(16'hffff, 16'hffff, 16'h0000);
		send_random(200);
		wait_for_results();

		// back to the usual x-frame mix; receiver holds off while items pile up
		write_settings({4'ha, MIX_SIGNS_RST}, ESC_MIN_RST, ESC_MAX_RST);
		hold_request = 150;
		steady = 1'b1;
		send_random(60);
		steady = 1'b0;
		send_random(150);
		wait_for_results();

		// equal end points
		span_a = 16'($urandom());
		write_settings(16'($urandom()), span_a, span_a);
		send_random(200);
		wait_for_results();

		for (int p = 0; p < 2; p++) begin
			span_a = 16'($urandom());
			span_b = 16'($urandom());
			write_settings(16'($urandom()), span_a, span_b);
			send_random(220);
			wait_for_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d mixer results from %0d accepted items", tracker.cmds_checked,
			tracker.frames_taken);
		$display("%0d register settings, link on and off, stalls and a long hold-off",
			settings_used);
		if (tracker.mismatches == 0 && tracker.expected_cmds.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", tracker.mismatches,
				tracker.expected_cmds.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> quad_motor_mixer_raw_top.f
sv/qmm_pkg.sv
sv/qmm_term.sv
sv/qmm_pulse.sv
sv/quad_motor_mixer_raw_top.sv
verif/testbench.sv
